FILE: design/gls_pkg.sv
// gls_pkg: shared types and constants of the galvo line stepper
// no dependencies
package gls_pkg;

	localparam int RING_DEPTH_DEF = 16;
	localparam int COORD_BITS_DEF = 24;
	localparam logic [15:0] CENTER = 16'h8000;
	localparam logic [15:0] WORD_MAX = 16'hffff;
	localparam logic [4:0] DELAY_RESET = 5'd14;

	localparam logic REG_BLANK_PATTERN = 1'b0;
	localparam logic REG_DELAY_LENGTH = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_STEP  = 2'd1,
		PH_END   = 2'd2,
		PH_DWELL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SQRT,
		CS_DIVX,
		CS_DIVY,
		CS_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture load fields, start distance
		logic sqrt_step; // one square root iteration
		logic div_start; // set up divider for x (0) or y (1)
		logic div_sel;
		logic div_step;
		logic finish;    // commit segment
		logic tick;      // produce one sample
	} gls_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sqrt_done;
		logic len_zero;
		logic div_done;
		logic busy;
	} gls_sts_t;

endpackage

FILE: design/gls_if.sv
// gls_if: valid/ready channel interfaces for input items, results and config
// depends on nothing
interface gls_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [23:0] target_x;
	logic [23:0] target_y;
	logic [22:0] step_length;
	logic [9:0]  laser_pattern;
	logic [7:0]  start_blank;
	logic        keep_blank;
	logic [7:0]  dwell_count;
	modport source (output valid, command, target_x, target_y, step_length, laser_pattern,
		start_blank, keep_blank, dwell_count, input ready);
	modport sink (input valid, command, target_x, target_y, step_length, laser_pattern,
		start_blank, keep_blank, dwell_count, output ready);
endinterface

interface gls_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] galvo_x;
	logic [15:0] galvo_y;
	logic [9:0]  laser_word;
	logic        segment_done;
	modport source (output valid, galvo_x, galvo_y, laser_word, segment_done, input ready);
	modport sink (input valid, galvo_x, galvo_y, laser_word, segment_done, output ready);
endinterface

interface gls_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [9:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gls_ctrl.sv
// gls_ctrl: sequencing state machine for loads and ticks
// depends on gls_pkg
module gls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_command,
	input  logic                out_free,
	input  gls_pkg::gls_sts_t   sts,
	output gls_pkg::gls_cmd_t   cmd
);

	gls_pkg::ctrl_state_t state_q, state_d;
	logic acc;

	assign acc = in_valid && in_ready;

	always_comb begin
		in_ready = (state_q == gls_pkg::CS_IDLE) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gls_pkg::CS_IDLE: begin
				if (acc && in_command == gls_pkg::CMD_LOAD && !sts.busy)
					state_d = gls_pkg::CS_SQRT;
			end
			gls_pkg::CS_SQRT: begin
				if (sts.sqrt_done)
					state_d = sts.len_zero ? gls_pkg::CS_IDLE : gls_pkg::CS_DIVX;
			end
			gls_pkg::CS_DIVX: begin
				if (sts.div_done) state_d = gls_pkg::CS_DIVY;
			end
			gls_pkg::CS_DIVY: begin
				if (sts.div_done) state_d = gls_pkg::CS_FINISH;
			end
			gls_pkg::CS_FINISH: state_d = gls_pkg::CS_IDLE;
			default: state_d = gls_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			gls_pkg::CS_IDLE: begin
				cmd.load = acc && in_command == gls_pkg::CMD_LOAD && !sts.busy;
				cmd.tick = acc && in_command == gls_pkg::CMD_TICK;
			end
			gls_pkg::CS_SQRT: begin
				cmd.sqrt_step = !sts.sqrt_done;
				cmd.div_start = sts.sqrt_done && !sts.len_zero;
				cmd.div_sel = 1'b0;
			end
			gls_pkg::CS_DIVX: begin
				cmd.div_step = !sts.div_done;
				cmd.div_start = sts.div_done;
				cmd.div_sel = 1'b1;
			end
			gls_pkg::CS_DIVY: begin
				cmd.div_step = !sts.div_done;
				cmd.div_sel = 1'b1;
			end
			gls_pkg::CS_FINISH: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gls_pkg::CS_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: design/gls_dp.sv
// gls_dp: segment state, square root, divider, stepping and laser delay ring
// depends on gls_pkg
module gls_dp #(
	parameter int RING_DEPTH = gls_pkg::RING_DEPTH_DEF,
	parameter int COORD_BITS = gls_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gls_pkg::gls_cmd_t  cmd,
	output gls_pkg::gls_sts_t  sts,
	input  logic [23:0]        target_x,
	input  logic [23:0]        target_y,
	input  logic [22:0]        step_length,
	input  logic [9:0]         laser_pattern,
	input  logic [7:0]         start_blank,
	input  logic               keep_blank,
	input  logic [7:0]         dwell_count,
	input  logic [9:0]         blank_pattern,
	input  logic [4:0]         delay_length,
	output logic               res_valid,
	output logic [15:0]        res_x,
	output logic [15:0]        res_y,
	output logic [9:0]         res_laser,
	output logic               res_done
);

	localparam int CB = COORD_BITS;
	localparam int SQS = (CB > 31) ? 1 : 0;
	localparam int AB = CB + 1 - SQS;      // magnitude bits
	localparam int SB = 2 * AB + 2;        // sum of squares, even for bit pairs
	localparam int LB = (SB + 1) / 2;      // root bits
	localparam int RB = LB + SQS;          // length bits
	localparam int PB = CB + 1 + 23;       // |dist * step| bits
	localparam int DCW = $clog2(PB + 1);
	localparam int SCW = $clog2(LB + 1);
	localparam int RIW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RLW = $clog2(RING_DEPTH + 1);
	localparam int GW = (CB - 6 > 18) ? CB - 6 : 18; // galvo word before clamping

	logic signed [CB-1:0] pos_x_q, pos_y_q, end_x_q, end_y_q, dlt_x_q, dlt_y_q;
	logic [RB-1:0] rem_q;
	logic [22:0] step_q;
	logic [9:0] draw_q;
	logic [7:0] blank_q, dwell_q;
	gls_pkg::phase_t phase_q;

	logic signed [CB:0] dx_q, dy_q;
	logic [AB-1:0] ax_q, ay_q;

	// square: two narrow multiplies in successive steps, then root one bit pair per cycle
	logic [SB-1:0] sq_n_q;
	logic [LB-1:0] sq_r_q;
	logic [SCW-1:0] sq_cnt_q;
	logic [1:0] sq_ph_q;
	logic [RB-1:0] len_q;

	// restoring divider
	logic [PB-1:0] dv_num_q;
	logic [RB:0] dv_rem_q;
	logic [DCW-1:0] dv_cnt_q;
	logic dv_neg_q;
	logic signed [CB-1:0] qx_q;

	logic [9:0] ring_q [RING_DEPTH];
	logic [RIW-1:0] ring_idx_q;

	// sqrt iteration
	logic [SB-1:0] sq_pair;
	logic [LB+1:0] sq_trial;
	always_comb begin
		sq_trial = {sq_r_q, 2'b01};
		sq_pair = sq_n_q;
	end

	assign sts.sqrt_done = (sq_ph_q == 2'd3);
	assign sts.len_zero = (len_q == '0);
	assign sts.div_done = (dv_cnt_q == '0);
	assign sts.busy = (phase_q != gls_pkg::PH_IDLE);

	// divider operands
	logic signed [CB:0] dsel;
	logic [CB:0] dmag;
	logic [PB-1:0] prod;
	always_comb begin
		dsel = cmd.div_sel ? dy_q : dx_q;
		dmag = dsel[CB] ? (~dsel + 1'b1) : dsel;
		prod = PB'(dmag) * PB'(step_q);
	end

	logic [RB:0] dv_shift;
	logic [RB:0] dv_sub;
	logic [PB-1:0] qraw;
	always_comb begin
		dv_shift = {dv_rem_q[RB-1:0], dv_num_q[PB-1]};
		dv_sub = dv_shift - {1'b0, len_q};
		qraw = dv_neg_q ? (~dv_num_q + 1'b1) : dv_num_q;
	end

	// tick path
	gls_pkg::phase_t ph_a, ph_n;
	logic [RB-1:0] rem_n;
	logic signed [CB-1:0] px_n, py_n;
	logic [7:0] dw_n;
	logic [9:0] pat;
	logic signed [CB-9:0] xi, yi;
	logic signed [GW-1:0] gx, gy;
	logic [RLW-1:0] dlen;
	logic [RIW-1:0] widx;
	always_comb begin
		rem_n = rem_q;
		px_n = pos_x_q;
		py_n = pos_y_q;
		dw_n = dwell_q;
		if (phase_q == gls_pkg::PH_STEP) begin
			rem_n = rem_q - RB'(step_q);
			px_n = pos_x_q + dlt_x_q;
			py_n = pos_y_q + dlt_y_q;
		end else begin
			px_n = end_x_q;
			py_n = end_y_q;
			if (phase_q == gls_pkg::PH_DWELL) dw_n = dwell_q - 8'd1;
		end
		ph_a = phase_q;
		if (ph_a == gls_pkg::PH_STEP && !(rem_n > RB'(step_q))) ph_a = gls_pkg::PH_END;
		if (ph_a == gls_pkg::PH_END && px_n == end_x_q && py_n == end_y_q)
			ph_a = gls_pkg::PH_DWELL;
		if (ph_a == gls_pkg::PH_DWELL && dw_n == 8'd0) ph_a = gls_pkg::PH_IDLE;
		ph_n = ph_a;
		pat = (blank_q != 8'd0) ? blank_pattern : draw_q;
		// truncate toward zero
		xi = (CB-8)'((px_n + ((px_n < 0) ? CB'(255) : CB'(0))) >>> 8);
		yi = (CB-8)'((py_n + ((py_n < 0) ? CB'(255) : CB'(0))) >>> 8);
		gx = GW'(signed'({1'b0, gls_pkg::CENTER})) + GW'(xi);
		gy = GW'(signed'({1'b0, gls_pkg::CENTER})) - GW'(yi);
		if (delay_length == 5'd0) dlen = RLW'(1);
		else if (32'(delay_length) > RING_DEPTH) dlen = RLW'(RING_DEPTH);
		else dlen = RLW'(delay_length);
		widx = ((RLW'(ring_idx_q)) >= dlen) ? '0 : ring_idx_q;
	end

	function automatic logic [15:0] clampw(input logic signed [GW-1:0] v);
		if (v < 0) clampw = 16'd0;
		else if (v > GW'(signed'({1'b0, gls_pkg::WORD_MAX}))) clampw = gls_pkg::WORD_MAX;
		else clampw = v[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.tick && phase_q != gls_pkg::PH_IDLE) begin
			res_x <= clampw(gx);
			res_y <= clampw(gy);
			res_laser <= ring_q[widx];
			res_done <= (ph_n == gls_pkg::PH_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0; pos_y_q <= '0; end_x_q <= '0; end_y_q <= '0;
			dlt_x_q <= '0; dlt_y_q <= '0; rem_q <= '0; step_q <= '0;
			draw_q <= '0; blank_q <= '0; dwell_q <= '0;
			phase_q <= gls_pkg::PH_IDLE;
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
			ring_idx_q <= '0;
			res_valid <= 1'b0;
			sq_ph_q <= 2'd0; sq_cnt_q <= '0; sq_n_q <= '0; sq_r_q <= '0; len_q <= '0;
			dv_cnt_q <= '0; dv_num_q <= '0; dv_rem_q <= '0; dv_neg_q <= 1'b0;
			dx_q <= '0; dy_q <= '0; ax_q <= '0; ay_q <= '0; qx_q <= '0;
		end else begin
			res_valid <= cmd.tick && phase_q != gls_pkg::PH_IDLE;
			if (cmd.load) begin
				logic signed [CB-1:0] ex, ey;
				logic signed [CB:0] ddx, ddy;
				ex = CB'(signed'(target_x));
				ey = CB'(signed'(target_y));
				end_x_q <= ex;
				end_y_q <= ey;
				step_q <= (step_length == '0) ? 23'd1 : step_length;
				draw_q <= laser_pattern;
				if (!keep_blank) blank_q <= start_blank;
				dwell_q <= dwell_count;
				ddx = {ex[CB-1], ex} - {pos_x_q[CB-1], pos_x_q};
				ddy = {ey[CB-1], ey} - {pos_y_q[CB-1], pos_y_q};
				dx_q <= ddx;
				dy_q <= ddy;
				ax_q <= AB'((ddx[CB] ? (~ddx + 1'b1) : ddx) >> SQS);
				ay_q <= AB'((ddy[CB] ? (~ddy + 1'b1) : ddy) >> SQS);
				sq_ph_q <= 2'd0;
				sq_cnt_q <= SCW'(LB);
				sq_r_q <= '0;
			end
			if (cmd.sqrt_step) begin
				if (sq_ph_q == 2'd0) begin
					sq_n_q <= SB'(ax_q) * SB'(ax_q);
					sq_ph_q <= 2'd1;
				end else if (sq_ph_q == 2'd1) begin
					sq_n_q <= sq_n_q + SB'(ay_q) * SB'(ay_q);
					len_q <= '0;
					sq_ph_q <= 2'd2;
				end else begin
					// digit recurrence: len_q holds partial remainder
					logic [LB+1:0] rr;
					logic [RB-1:0] rlo;
					logic take;
					rr = {len_q[LB-1:0], sq_pair[SB-1 -: 2]};
					take = (rr >= sq_trial);
					if (take) begin
						rr = rr - sq_trial;
						sq_r_q <= {sq_r_q[LB-2:0], 1'b1};
					end else begin
						sq_r_q <= {sq_r_q[LB-2:0], 1'b0};
					end
					rlo = RB'(rr);
					sq_n_q <= {sq_n_q[SB-3:0], 2'b00};
					sq_cnt_q <= sq_cnt_q - 1'b1;
					if (sq_cnt_q == SCW'(1)) begin
						sq_ph_q <= 2'd3;
						len_q <= RB'({sq_r_q[LB-2:0], take}) << SQS;
					end else begin
						len_q <= rlo;
					end
				end
			end
			if (cmd.div_start) begin
				dv_num_q <= prod;
				dv_neg_q <= dsel[CB];
				dv_rem_q <= '0;
				dv_cnt_q <= DCW'(PB);
				if (cmd.div_sel) qx_q <= CB'(qraw);
			end
			if (cmd.div_step) begin
				logic nb;
				nb = !dv_sub[RB];
				dv_rem_q <= nb ? dv_sub : dv_shift;
				dv_num_q <= {dv_num_q[PB-2:0], nb};
				dv_cnt_q <= dv_cnt_q - 1'b1;
			end
			if (cmd.finish) begin
				dlt_x_q <= qx_q;
				dlt_y_q <= CB'(qraw);
				rem_q <= len_q;
				if (!(len_q > RB'(step_q))) begin
					if (pos_x_q == end_x_q && pos_y_q == end_y_q)
						phase_q <= (dwell_q == 8'd0) ? gls_pkg::PH_IDLE : gls_pkg::PH_DWELL;
					else
						phase_q <= gls_pkg::PH_END;
				end else begin
					phase_q <= gls_pkg::PH_STEP;
				end
			end
			if (cmd.tick && phase_q != gls_pkg::PH_IDLE) begin
				rem_q <= rem_n;
				pos_x_q <= px_n;
				pos_y_q <= py_n;
				dwell_q <= dw_n;
				phase_q <= ph_n;
				if (blank_q != 8'd0) blank_q <= blank_q - 8'd1;
				ring_q[widx] <= pat;
				ring_idx_q <= (32'(widx) + 1 >= RING_DEPTH) ? '0 : widx + 1'b1;
			end
		end
	end

endmodule

FILE: design/gls_outbuf.sv
// gls_outbuf: result register holding one sample until the sink takes it
// depends on gls_if
module gls_outbuf (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] x,
	input  logic [15:0] y,
	input  logic [9:0]  laser,
	input  logic        done,
	output logic        free,
	gls_out_if.source   o
);

	logic full_q;
	logic [15:0] x_q, y_q;
	logic [9:0] l_q;
	logic d_q;

	assign free = !full_q;
	assign o.valid = full_q;
	assign o.galvo_x = x_q;
	assign o.galvo_y = y_q;
	assign o.laser_word = l_q;
	assign o.segment_done = d_q;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x; y_q <= y; l_q <= laser; d_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (load) full_q <= 1'b1;
		else if (o.ready) full_q <= 1'b0;
	end

endmodule

FILE: design/galvo_line_stepper_core.sv
// A segment load forms the squared distance and takes its bit-serial square root,
// then, unless the length is zero, runs two divisions for the x and y steps and
// commits the segment. A tick computes the sample into the datapath result
// register, which then fills the output register for the hand-off to the result
// side; a new item is taken only once the previous sample has been handed off.
module galvo_line_stepper_core #(
	parameter int RING_DEPTH = gls_pkg::RING_DEPTH_DEF,
	parameter int COORD_BITS = gls_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gls_in_if.sink    in_ch,
	gls_out_if.source out_ch,
	gls_cfg_if.sink   cfg
);

	gls_pkg::gls_cmd_t cmd;
	gls_pkg::gls_sts_t sts;
	logic [9:0] blank_q;
	logic [4:0] delay_q;
	logic free, rv, rd;
	logic [15:0] rx, ry;
	logic [9:0] rl;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= '0;
			delay_q <= gls_pkg::DELAY_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == gls_pkg::REG_BLANK_PATTERN) blank_q <= cfg.data;
			else delay_q <= cfg.data[4:0];
		end
	end

	gls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_command(in_ch.command), .out_free(free && !rv), .sts(sts), .cmd(cmd)
	);

	gls_dp #(.RING_DEPTH(RING_DEPTH), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.target_x(in_ch.target_x), .target_y(in_ch.target_y),
		.step_length(in_ch.step_length), .laser_pattern(in_ch.laser_pattern),
		.start_blank(in_ch.start_blank), .keep_blank(in_ch.keep_blank),
		.dwell_count(in_ch.dwell_count), .blank_pattern(blank_q), .delay_length(delay_q),
		.res_valid(rv), .res_x(rx), .res_y(ry), .res_laser(rl), .res_done(rd)
	);

	gls_outbuf u_ob (
		.clk(clk), .arst_n(arst_n), .load(rv), .x(rx), .y(ry), .laser(rl), .done(rd),
		.free(free), .o(out_ch)
	);

endmodule
